### hw/rtl/arpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, codes and constants shared by the ARP responder and cache blocks.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 128;

  localparam int unsigned MAC_W     = 48;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned HDR_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 48;

  localparam logic [HDR_W-1:0] HW_ETHERNET = 16'h0001;
  localparam logic [HDR_W-1:0] PROTO_IPV4  = 16'h0800;
  localparam logic [HDR_W-1:0] OPC_REQUEST = 16'h0001;
  localparam logic [HDR_W-1:0] OPC_REPLY   = 16'h0002;
  localparam logic [IP_W-1:0]  BCAST_IP    = '1;
  localparam logic [MAC_W-1:0] BCAST_MAC   = '1;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] TX_NONE    = 2'd0;
  localparam logic [1:0] TX_REPLY   = 2'd1;
  localparam logic [1:0] TX_REQUEST = 2'd2;

  localparam logic [1:0] LK_NONE = 2'd0;
  localparam logic [1:0] LK_HIT  = 2'd1;
  localparam logic [1:0] LK_MISS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd1;

  typedef struct packed {
    logic             op;
    logic [HDR_W-1:0] hw_type;
    logic [HDR_W-1:0] proto_type;
    logic [HDR_W-1:0] arp_opcode;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [MAC_W-1:0] target_mac;
    logic [IP_W-1:0]  target_ip;
    logic [IP_W-1:0]  lookup_ip;
  } in_t;

  typedef struct packed {
    logic [1:0]       tx_kind;
    logic [MAC_W-1:0] tx_dest_mac;
    logic [IP_W-1:0]  tx_target_ip;
    logic [1:0]       lookup_status;
    logic [MAC_W-1:0] lookup_mac;
  } out_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/arpc_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_mem
// Cache entry memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module arpc_mem #(
  parameter int unsigned DEPTH = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire arpc_pkg::entry_t       wr_data,
  input  wire [$clog2(DEPTH)-1:0]     rd_addr,
  output arpc_pkg::entry_t            rd_data
);
  import arpc_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hw/rtl/arpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_ctrl
// Request decode, sequential cache scan with one shared address comparator,
// entry insert and result register.
// ----------------------------------------------------------------------------
module arpc_ctrl #(
  parameter int unsigned DEPTH = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire arpc_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output arpc_pkg::out_t                    out_data,
  input  wire [arpc_pkg::MAC_W-1:0]         own_mac,
  input  wire [arpc_pkg::IP_W-1:0]          own_ip,
  output logic                              mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]          mem_wr_addr,
  output arpc_pkg::entry_t                  mem_wr_data,
  output logic [$clog2(DEPTH)-1:0]          mem_rd_addr,
  input  wire arpc_pkg::entry_t             mem_rd_data
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  state_t           state_r,     state_nxt;
  logic [IP_W-1:0]  key_r,       key_nxt;
  logic [MAC_W-1:0] mac_r,       mac_nxt;
  logic             lookup_r,    lookup_nxt;
  logic [CNT_W-1:0] scan_addr_r, scan_addr_nxt;
  logic             chk_vld_r,   chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r,   chk_idx_nxt;
  logic [CNT_W-1:0] fill_r,      fill_nxt;
  logic [IDX_W-1:0] ptr_r,       ptr_nxt;
  logic [IDX_W-1:0] slot_r,      slot_nxt;
  out_t             res_r,       res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r,  out_data_nxt;

  logic hit;
  logic issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_vld_r   <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    mac_r       <= mac_nxt;
    lookup_r    <= lookup_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    slot_r      <= slot_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // shared comparator on the registered read data
  assign hit   = chk_vld_r && (mem_rd_data.ip == key_r);
  assign issue = scan_addr_r < fill_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    mac_nxt       = mac_r;
    lookup_nxt    = lookup_r;
    scan_addr_nxt = scan_addr_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    slot_nxt      = slot_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = slot_r;
    mem_wr_data   = '{ip: key_r, mac: mac_r};
    mem_rd_addr   = scan_addr_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          res_nxt       = '0;
          scan_addr_nxt = '0;
          state_nxt     = ST_DONE;
          if (in_data.op == OP_PACKET) begin
            lookup_nxt = 1'b0;
            key_nxt    = in_data.sender_ip;
            mac_nxt    = in_data.sender_mac;
            if (in_data.hw_type == HW_ETHERNET && in_data.proto_type == PROTO_IPV4) begin
              if (in_data.arp_opcode == OPC_REQUEST) begin
                if (in_data.target_ip == own_ip) begin
                  res_nxt.tx_kind      = TX_REPLY;
                  res_nxt.tx_dest_mac  = in_data.sender_mac;
                  res_nxt.tx_target_ip = in_data.sender_ip;
                end
              end else if (in_data.arp_opcode == OPC_REPLY) begin
                if (in_data.target_mac == own_mac) begin
                  state_nxt = ST_SCAN;
                end
              end
            end
          end else begin
            lookup_nxt = 1'b1;
            key_nxt    = in_data.lookup_ip;
            if (in_data.lookup_ip == BCAST_IP) begin
              res_nxt.lookup_status = LK_HIT;
              res_nxt.lookup_mac    = BCAST_MAC;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          if (lookup_r) begin
            res_nxt.lookup_status = LK_HIT;
            res_nxt.lookup_mac    = mem_rd_data.mac;
            state_nxt             = ST_DONE;
          end else begin
            slot_nxt  = chk_idx_r;
            state_nxt = ST_WRITE;
          end
        end else begin
          chk_vld_nxt = issue;
          chk_idx_nxt = scan_addr_r[IDX_W-1:0];
          if (issue) begin
            scan_addr_nxt = scan_addr_r + CNT_W'(1);
          end else if (!chk_vld_r) begin
            // scan exhausted without a match
            if (lookup_r) begin
              res_nxt.tx_kind       = TX_REQUEST;
              res_nxt.tx_dest_mac   = BCAST_MAC;
              res_nxt.tx_target_ip  = key_r;
              res_nxt.lookup_status = LK_MISS;
              state_nxt             = ST_DONE;
            end else begin
              if (fill_r < FULL) begin
                slot_nxt = fill_r[IDX_W-1:0];
                fill_nxt = fill_r + CNT_W'(1);
              end else begin
                slot_nxt = ptr_r;
                ptr_nxt  = (ptr_r == LAST_IDX) ? '0 : ptr_r + IDX_W'(1);
              end
              state_nxt = ST_WRITE;
            end
          end
        end
      end

      ST_WRITE: begin
        mem_wr_en = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### hw/rtl/arp_responder_with_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP request responder with an IPv4-to-MAC cache and round-robin eviction.
// ----------------------------------------------------------------------------
// timing: a cache lookup or insert scans the entries in order, comparing one entry
//   per cycle; a request without cache access goes straight to the result register
// flow: one request at a time; the next is accepted after the result is registered,
//   which waits while a stalled output still holds the previous result
// reset: synchronous, clears the fill count, eviction pointer, own_mac, own_ip and
//   the output valid; no clearing pass
module arp_responder_with_cache #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire arpc_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output arpc_pkg::out_t                    out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [arpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [arpc_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);

  logic [MAC_W-1:0] own_mac_r;
  logic [IP_W-1:0]  own_ip_r;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OWN_MAC) begin
        own_mac_r <= cfg_data[MAC_W-1:0];
      end
      if (cfg_index == CFG_OWN_IP) begin
        own_ip_r <= cfg_data[IP_W-1:0];
      end
    end
  end

  arpc_ctrl #(
    .DEPTH (CACHE_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .own_mac     (own_mac_r),
    .own_ip      (own_ip_r),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  arpc_mem #(
    .DEPTH (CACHE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
`default_nettype wire

### hw/rtl/arpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks for the ARP responder, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire arpc_pkg::out_t out_data
);
  import arpc_pkg::*;

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a request is processed alone
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while busy");

  // a broadcast request goes out exactly on a lookup miss
  a_miss_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.tx_kind == TX_REQUEST) == (out_data.lookup_status == LK_MISS)))
    else $error("request frame and miss status disagree");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind arp_responder_with_cache arpc_checker u_chk (.*);
`default_nettype wire

### sim/arp_responder_with_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_with_cache_tb
// Self-checking bench for the ARP responder and cache. A directed table covers
// header filtering, opcodes, replies to us, cache insert, update and broadcast
// rules. Random phases follow, each with new interface addresses, mixing
// well-formed replies, requests and lookups (replies and lookups over a shared
// address pool, so the cache fills and evicts) with broken and random packets.
// Each result is compared field by field against a cycle-free bench cache model.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_tb;
  import arpc_pkg::*;

  localparam int unsigned ENTRIES      = CACHE_ENTRIES_DEF;
  localparam int unsigned POOL_SIZE    = 192;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 215;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DAT_W-1:0]   cfg_val;
    in_t                    item;
    bit                     has_result;
    out_t                   result;
  } row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // bench copy of the block state
  logic             cache_valid [ENTRIES];
  logic [IP_W-1:0]  cache_ip    [ENTRIES];
  logic [MAC_W-1:0] cache_mac   [ENTRIES];
  int unsigned      cache_victim = 0;
  logic [MAC_W-1:0] own_mac_q    = '0;
  logic [IP_W-1:0]  own_ip_q     = '0;

  out_t        pending_arp_results[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_left     = 0;
  bit          no_idle        = 1'b0;
  logic [IP_W-1:0] pool_base  = '0;

  always #1 clk = ~clk;

  arp_responder_with_cache #(
    .CACHE_ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  function automatic int find_cached(input logic [IP_W-1:0] ip);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (cache_valid[i] && cache_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  function automatic void learn_mapping(input logic [IP_W-1:0] ip,
                                        input logic [MAC_W-1:0] mac);
    int slot;
    int i;
    slot = find_cached(ip);
    for (i = 0; i < ENTRIES && slot < 0; i++) begin
      if (!cache_valid[i]) slot = i;
    end
    if (slot < 0) begin
      slot = cache_victim;
      cache_victim = (cache_victim + 1) % ENTRIES;
    end
    cache_valid[slot] = 1'b1;
    cache_ip[slot]    = ip;
    cache_mac[slot]   = mac;
  endfunction

  function automatic out_t compute_arp_result(input in_t x);
    out_t r;
    int   slot;
    r = '0;
    if (x.op == OP_PACKET) begin
      if (x.hw_type == HW_ETHERNET && x.proto_type == PROTO_IPV4) begin
        if (x.arp_opcode == OPC_REQUEST) begin
          if (x.target_ip == own_ip_q) begin
            r.tx_kind      = TX_REPLY;
            r.tx_dest_mac  = x.sender_mac;
            r.tx_target_ip = x.sender_ip;
          end
        end else if (x.arp_opcode == OPC_REPLY && x.target_mac == own_mac_q) begin
          learn_mapping(x.sender_ip, x.sender_mac);
        end
      end
    end else if (x.lookup_ip == BCAST_IP) begin
      r.lookup_status = LK_HIT;
      r.lookup_mac    = BCAST_MAC;
    end else begin
      slot = find_cached(x.lookup_ip);
      if (slot >= 0) begin
        r.lookup_status = LK_HIT;
        r.lookup_mac    = cache_mac[slot];
      end else begin
        r.tx_kind       = TX_REQUEST;
        r.tx_dest_mac   = BCAST_MAC;
        r.tx_target_ip  = x.lookup_ip;
        r.lookup_status = LK_MISS;
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [IP_W-1:0] pool_ip();
    return pool_base | 32'($urandom_range(0, POOL_SIZE - 1));
  endfunction

  function automatic in_t pkt(input logic [HDR_W-1:0] hw, input logic [HDR_W-1:0] proto,
                              input logic [HDR_W-1:0] opc,
                              input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
                              input logic [MAC_W-1:0] tmac, input logic [IP_W-1:0] tip);
    in_t x;
    x.op         = OP_PACKET;
    x.hw_type    = hw;
    x.proto_type = proto;
    x.arp_opcode = opc;
    x.sender_mac = smac;
    x.sender_ip  = sip;
    x.target_mac = tmac;
    x.target_ip  = tip;
    x.lookup_ip  = $urandom;
    return x;
  endfunction

  function automatic in_t lkp(input logic [IP_W-1:0] ip);
    in_t x;
    x = pkt(16'($urandom), 16'($urandom), 16'($urandom), rand_mac(), $urandom,
            rand_mac(), $urandom);
    x.op        = OP_LOOKUP;
    x.lookup_ip = ip;
    return x;
  endfunction

  function automatic out_t res(input logic [1:0] kind, input logic [MAC_W-1:0] dmac,
                               input logic [IP_W-1:0] dip, input logic [1:0] status,
                               input logic [MAC_W-1:0] lmac);
    out_t r;
    r.tx_kind       = kind;
    r.tx_dest_mac   = dmac;
    r.tx_target_ip  = dip;
    r.lookup_status = status;
    r.lookup_mac    = lmac;
    return r;
  endfunction

  function automatic row_t typed_row(input in_t x, input out_t r);
    row_t row;
    row.kind       = ROW_ITEM;
    row.cfg_idx    = '0;
    row.cfg_val    = '0;
    row.item       = x;
    row.has_result = 1'b1;
    row.result     = r;
    return row;
  endfunction

  function automatic row_t checked_row(input in_t x);
    row_t row;
    row = typed_row(x, '0);
    row.has_result = 1'b0;
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] val);
    row_t row;
    row = typed_row('0, '0);
    row.kind    = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic in_t random_arp_item();
    in_t         x;
    int unsigned r;
    x = pkt(HW_ETHERNET, PROTO_IPV4, OPC_REPLY, rand_mac(), pool_ip(), own_mac_q, $urandom);
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if ($urandom_range(0, 19) == 0) x.sender_ip = BCAST_IP;
    end else if (r < 55) begin
      x.arp_opcode = OPC_REQUEST;
      x.sender_ip  = $urandom;
      x.target_mac = rand_mac();
      x.target_ip  = own_ip_q;
    end else if (r < 80) begin
      case ($urandom_range(0, 9))
        0:       x = lkp(BCAST_IP);
        1, 2:    x = lkp($urandom);
        default: x = lkp(pool_ip());
      endcase
    end else if (r < 90) begin
      // nearly valid, with a broken header field, opcode or target address
      x.arp_opcode = $urandom_range(0, 1) ? OPC_REPLY : OPC_REQUEST;
      x.target_ip  = own_ip_q;
      case ($urandom_range(0, 3))
        0: x.hw_type    = 16'($urandom);
        1: x.proto_type = 16'($urandom);
        2: x.arp_opcode = 16'($urandom);
        default: begin
          x.target_mac[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
          x.target_ip[$urandom_range(0, IP_W - 1)]   ^= 1'b1;
        end
      endcase
    end else begin
      x = pkt(16'($urandom), 16'($urandom), 16'($urandom), rand_mac(), $urandom,
              rand_mac(), $urandom);
      x.op = 1'($urandom);
    end
    return x;
  endfunction

  task automatic send_item(input in_t x, input bit has_result, input out_t result);
    out_t        predicted;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = compute_arp_result(x);
    pending_arp_results.push_back(has_result ? result : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_arp_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_MAC: own_mac_q = val;
      CFG_OWN_IP:  own_ip_q  = val[IP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] expv,
                             input logic [63:0] actv);
    if (actv !== expv) begin
      mismatch_count++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, expv, actv);
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin : rx_side
    out_t        want;
    int unsigned n;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_arp_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result expected none actual %h", $time, out_data);
      end else begin
        want = pending_arp_results.pop_front();
        check_field("tx_kind", 64'(want.tx_kind), 64'(out_data.tx_kind));
        check_field("tx_dest_mac", 64'(want.tx_dest_mac), 64'(out_data.tx_dest_mac));
        check_field("tx_target_ip", 64'(want.tx_target_ip), 64'(out_data.tx_target_ip));
        check_field("lookup_status", 64'(want.lookup_status),
                    64'(out_data.lookup_status));
        check_field("lookup_mac", 64'(want.lookup_mac), 64'(out_data.lookup_mac));
      end
    end
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap();
      out_stall  <= (n > 0);
      stall_left <= (n > 0) ? n - 1 : 0;
    end
  end

  initial begin
    #3000000;
    $display("FAIL arp_responder_with_cache");
    $finish;
  end

  initial begin : stimulus
    row_t             directed[$];
    row_t             row;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      i;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;

    for (i = 0; i < ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
    end
    pool_base = {24'($urandom), 8'h00};

    // addresses are zero out of reset
    directed.push_back(typed_row(lkp(32'h0A00_0001),
                       res(TX_REQUEST, BCAST_MAC, 32'h0A00_0001, LK_MISS, '0)));
    directed.push_back(typed_row(lkp(BCAST_IP), res(TX_NONE, '0, '0, LK_HIT, BCAST_MAC)));
    directed.push_back(typed_row(lkp('0), res(TX_REQUEST, BCAST_MAC, '0, LK_MISS, '0)));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REQUEST, BCAST_MAC,
                                     BCAST_IP, '0, '0),
                       res(TX_REPLY, BCAST_MAC, BCAST_IP, LK_NONE, '0)));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REQUEST, rand_mac(),
                                     $urandom, '0, BCAST_IP), '0));
    directed.push_back(typed_row(pkt(16'h0000, PROTO_IPV4, OPC_REQUEST, rand_mac(),
                                     $urandom, '0, '0), '0));
    directed.push_back(typed_row(pkt(16'hFFFF, PROTO_IPV4, OPC_REQUEST, rand_mac(),
                                     $urandom, '0, '0), '0));
    directed.push_back(typed_row(pkt(HW_ETHERNET, 16'h0000, OPC_REPLY, rand_mac(),
                                     32'hC0A8_0105, '0, '0), '0));
    directed.push_back(typed_row(pkt(HW_ETHERNET, 16'hFFFF, OPC_REPLY, rand_mac(),
                                     32'hC0A8_0105, '0, '0), '0));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, 16'h0000, rand_mac(),
                                     32'hC0A8_0105, '0, '0), '0));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, 16'hFFFF, rand_mac(),
                                     32'hC0A8_0105, '0, '0), '0));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, 16'h0003, rand_mac(),
                                     32'hC0A8_0105, '0, '0), '0));
    directed.push_back(checked_row(lkp(32'hC0A8_0105)));
    // cache insert, then update in place
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REPLY,
                                     48'h0200_0000_0001, 32'hC0A8_0101, '0, '0), '0));
    directed.push_back(checked_row(lkp(32'hC0A8_0101)));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REPLY, rand_mac(),
                                     32'hC0A8_0102, 48'h1, '0), '0));
    directed.push_back(checked_row(lkp(32'hC0A8_0102)));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REPLY, BCAST_MAC,
                                     32'hC0A8_0101, '0, '0), '0));
    directed.push_back(checked_row(lkp(32'hC0A8_0101)));
    // a cached broadcast address never answers a broadcast lookup
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REPLY,
                                     48'h1234_5678_9ABC, BCAST_IP, '0, '0), '0));
    directed.push_back(typed_row(lkp(BCAST_IP), res(TX_NONE, '0, '0, LK_HIT, BCAST_MAC)));
    // all-ones addresses, spare indexes ignored
    directed.push_back(cfg_row(CFG_OWN_MAC, BCAST_MAC));
    directed.push_back(cfg_row(CFG_OWN_IP, '1));
    directed.push_back(cfg_row(CFG_SPARE_A, '0));
    directed.push_back(cfg_row(CFG_SPARE_B, '1));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REQUEST, '0, '0,
                                     rand_mac(), BCAST_IP),
                       res(TX_REPLY, '0, '0, LK_NONE, '0)));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REPLY, '0, '0,
                                     BCAST_MAC, '0), '0));
    directed.push_back(checked_row(lkp('0)));
    directed.push_back(typed_row(pkt(HW_ETHERNET, PROTO_IPV4, OPC_REPLY, rand_mac(),
                                     32'hC0A8_0103, '0, '0), '0));
    directed.push_back(checked_row(lkp(32'hC0A8_0103)));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      row = directed[k];
      if (row.kind == ROW_CFG) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        send_item(row.item, row.has_result, row.result);
      end
    end
    in_valid <= 1'b0;
    wait_idle();

    for (phase = 0; phase < PHASES; phase++) begin
      no_idle = (phase == 2);
      case (phase)
        0: begin mac = '0;         ip = '0;        end
        1: begin mac = BCAST_MAC;  ip = BCAST_IP;  end
        default: begin mac = rand_mac(); ip = $urandom; end
      endcase
      write_reg(CFG_OWN_MAC, mac);
      write_reg(CFG_OWN_IP, {16'($urandom), ip});
      if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                          rand_mac());
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) begin
          // hold off until the block has drained
          in_valid <= 1'b0;
          wait_idle();
        end
        send_item(random_arp_item(), 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    no_idle = 1'b0;
    repeat (ENTRIES + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_arp_results.size() == 0) begin
      $display("PASS arp_responder_with_cache");
    end else begin
      $display("FAIL arp_responder_with_cache");
    end
    $finish;
  end

endmodule

### arp_responder_with_cache.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_mem.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arp_responder_with_cache.sv
hw/rtl/arpc_checker.sv
sim/arp_responder_with_cache_tb.sv
